FILE: rtl/cpw_pkg.sv
// Shared types and constants for the cyclic piecewise-linear warp block.
// Used by cpw_muldiv and cyclic_piecewise_linear_warp; depends on nothing.
package cpw_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int VALUE_BITS_DEF = 16;
    localparam int FUNC_BITS      = 2;
    localparam int INDEX_BITS     = 4;
    localparam int COUNT_BITS     = 5;

    typedef enum logic [1:0] {
        FN_LOAD   = 2'd0,
        FN_COMMIT = 2'd1,
        FN_FWD    = 2'd2,
        FN_INV    = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CMT_RD,
        S_CMT_CMP,
        S_W_MODW,
        S_W_RD,
        S_W_CMP,
        S_W_LAST,
        S_W_LERP,
        S_W_DIV
    } t_state;

    typedef enum logic {
        MD_MOD,
        MD_MULDIV
    } t_md_op;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } t_md_state;

    typedef struct packed {
        logic   go;
        t_md_op op;
    } t_md_cmd;

endpackage

FILE: rtl/cpw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module cpw_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/cpw_muldiv.sv
// Shared bit-serial arithmetic unit: modulo reduction, or multiply then divide.
// Depends on cpw_pkg for the command struct and the unit's state type.
module cpw_muldiv
    import cpw_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_md_cmd             i_cmd,
    input  logic [VALUE_BITS:0] i_num,
    input  logic [VALUE_BITS:0] i_mul,
    input  logic [VALUE_BITS:0] i_den,
    output logic                o_done,
    output logic [VALUE_BITS:0] o_quo,
    output logic [VALUE_BITS:0] o_rem
);

    localparam int VB = VALUE_BITS;
    localparam int MW = VB + 1;
    localparam int PW = 2 * VB;
    localparam int RW = VB + 2;
    localparam int SW = $clog2(PW + 1);

    t_md_state r_st, n_st;
    logic      r_done, n_done;

    logic [PW-1:0] r_p;
    logic [RW-1:0] r_rem;
    logic [MW-1:0] r_mcand;
    logic [MW-1:0] r_mplier;
    logic [MW-1:0] r_den;
    logic [SW-1:0] r_cnt;

    logic [RW-1:0] trial;
    logic [RW-1:0] diff;
    logic          ge;
    logic [PW-1:0] addend;
    logic [PW-1:0] mul_sum;
    logic          last_step;

    always_comb begin
        trial     = {r_rem[MW-1:0], r_p[PW-1]};
        ge        = trial >= RW'(r_den);
        diff      = trial - RW'(r_den);
        addend    = r_mplier[MW-1] ? PW'(r_mcand) : '0;
        mul_sum   = {r_p[PW-2:0], 1'b0} + addend;
        last_step = r_cnt == SW'(1);
    end

    always_comb begin
        n_st   = r_st;
        n_done = 1'b0;
        case (r_st)
            MD_IDLE: begin
                if (i_cmd.go) begin
                    n_st = (i_cmd.op == MD_MOD) ? MD_DIV : MD_MUL;
                end
            end
            MD_MUL: begin
                if (last_step) begin
                    n_st = MD_DIV;
                end
            end
            MD_DIV: begin
                if (last_step) begin
                    n_st   = MD_IDLE;
                    n_done = 1'b1;
                end
            end
            default: n_st = MD_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= MD_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
    end

    // The modulo runs the divider alone over the upper half of the word; the
    // multiply-divide first builds the product MSB first, then divides it.
    always_ff @(posedge i_clk) begin
        case (r_st)
            MD_IDLE: begin
                if (i_cmd.go) begin
                    r_den <= i_den;
                    r_rem <= '0;
                    if (i_cmd.op == MD_MOD) begin
                        r_p   <= {i_num[VB-1:0], {VB{1'b0}}};
                        r_cnt <= SW'(VB);
                    end else begin
                        r_p      <= '0;
                        r_mcand  <= i_num;
                        r_mplier <= i_mul;
                        r_cnt    <= SW'(MW);
                    end
                end
            end
            MD_MUL: begin
                r_p      <= mul_sum;
                r_mplier <= {r_mplier[MW-2:0], 1'b0};
                if (last_step) begin
                    r_cnt <= SW'(PW);
                    r_rem <= '0;
                end else begin
                    r_cnt <= r_cnt - SW'(1);
                end
            end
            MD_DIV: begin
                r_p   <= {r_p[PW-2:0], ge};
                r_rem <= ge ? diff : trial;
                r_cnt <= r_cnt - SW'(1);
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_quo  = r_p[MW-1:0];
    assign o_rem  = r_rem[MW-1:0];

endmodule

FILE: rtl/cyclic_piecewise_linear_warp.sv
// Cyclic piecewise-linear warp: top level with the sequencer and table banks.
// Depends on cpw_pkg, cpw_ram and cpw_muldiv.
//
// Usage: an item is taken on a rising edge with start high and busy low. The
// func field picks load point, commit table, forward warp or inverse warp.
// Every item gives exactly one result, shown for one cycle with o_valid high;
// the receiver cannot hold it off. The modulus is written over the cfg
// channel (i_cfg_valid / o_cfg_ready) while the block is idle; the write also
// resets the active table to the identity, passing through the busy S_INIT state.
// Sequence: a load, or a commit with a bad count, finishes on its accept edge
// and o_valid follows in the next cycle. A commit reads and checks its points
// in turn (S_CMT_RD, S_CMT_CMP), stopping at the last or at one out of range.
// A warp first reduces the value modulo the modulus (S_W_MODW), then reads and
// tests one point at a time (S_W_RD, S_W_CMP) until a segment holds the value,
// else tests the closing segment (S_W_LAST); when the hit segment cannot be
// taken directly (S_W_LERP), it runs the serial multiply and divide (S_W_DIV).
// The shared bit-serial multiply/divide unit does both the modulo and the divide.
// After reset the block is busy in S_INIT while it writes table entry zero.
module cyclic_piecewise_linear_warp
    import cpw_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [FUNC_BITS-1:0]  i_func,
    input  logic [INDEX_BITS-1:0] i_point_index,
    input  logic [VALUE_BITS-1:0] i_raw_point,
    input  logic [VALUE_BITS-1:0] i_warped_point,
    input  logic [COUNT_BITS-1:0] i_point_count,
    input  logic [VALUE_BITS-1:0] i_value_in,
    output logic                  o_valid,
    output logic [VALUE_BITS-1:0] o_value_out,
    output logic                  o_status,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [VALUE_BITS:0]   i_cfg_modulus
);

    localparam int VB = VALUE_BITS;
    localparam int MW = VB + 1;
    localparam int RW = VB + 2;
    localparam int MP = MAX_POINTS;
    localparam int AW = $clog2(2 * MP);
    localparam int IW = (MP > 1) ? $clog2(MP) : 1;
    localparam int CW = $clog2(MP + 1);
    localparam logic [MW-1:0] M_MAX = {1'b1, {VB{1'b0}}};

    t_state r_state, n_state;

    logic [MW-1:0] r_mod;
    logic          r_bank;
    logic [CW-1:0] r_count;
    logic          r_ovalid;

    logic          r_inv;
    logic [CW-1:0] r_n;
    logic [IW-1:0] r_idx;
    logic [VB-1:0] r_v;
    logic [VB-1:0] r_first_in, r_first_out;
    logic [VB-1:0] r_prev_in, r_prev_out;
    logic [1:0]    r_rj, r_wj;
    logic [MW-1:0] r_a, r_b, r_d;
    logic [VB-1:0] r_lo;
    logic [VB-1:0] r_value_out;
    logic          r_status;

    logic          accept, cfg_we;
    logic [MW-1:0] cfg_m;
    logic          idx_ok, cnt_bad;
    logic [AW-1:0] base_act, base_stg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [VB-1:0] ram_wraw, ram_wwarp;
    logic [VB-1:0] rd_raw, rd_warp;
    logic [VB-1:0] cur_in, cur_out;

    t_md_cmd       md_cmd;
    logic [MW-1:0] md_num, md_den;
    logic          md_done;
    logic [MW-1:0] md_quo, md_rem;

    logic          is_first, is_last;
    logic          bad_range, wrap_bad;
    logic [VB-1:0] first_raw, first_warp;
    logic [2:0]    rj_sum, wj_sum;
    logic [1:0]    rj_next, wj_next;

    logic [RW-1:0] ei, ej, oi, oj, ev, em;
    logic          c1, c2, c3, wrap_seg, seg_hit;
    logic [RW-1:0] a_w, d_w, b_w;

    logic [MW-1:0] frac;
    logic [RW-1:0] sum, wrapped;
    logic          fin, fin_status;
    logic [VB-1:0] fin_value;
    logic          direct;

    assign busy        = r_state != S_IDLE;
    assign accept      = start && !busy;
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        if (i_cfg_modulus < MW'(2)) begin
            cfg_m = MW'(2);
        end else if (i_cfg_modulus > M_MAX) begin
            cfg_m = M_MAX;
        end else begin
            cfg_m = i_cfg_modulus;
        end
    end

    assign idx_ok   = 32'(i_point_index) < MAX_POINTS;
    assign cnt_bad  = (i_point_count == '0) || (32'(i_point_count) > MAX_POINTS);
    assign base_act = r_bank ? AW'(MP) : '0;
    assign base_stg = r_bank ? '0 : AW'(MP);

    cpw_ram #(.WIDTH(VB), .DEPTH(2 * MP)) u_raw_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wraw),
        .i_raddr (ram_raddr),
        .o_rdata (rd_raw)
    );

    cpw_ram #(.WIDTH(VB), .DEPTH(2 * MP)) u_warp_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wwarp),
        .i_raddr (ram_raddr),
        .o_rdata (rd_warp)
    );

    cpw_muldiv #(.VALUE_BITS(VB)) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (md_cmd),
        .i_num   (md_num),
        .i_mul   (r_b),
        .i_den   (md_den),
        .o_done  (md_done),
        .o_quo   (md_quo),
        .o_rem   (md_rem)
    );

    // The inverse warp reads the same entries with the two tables swapped.
    assign cur_in  = r_inv ? rd_warp : rd_raw;
    assign cur_out = r_inv ? rd_raw : rd_warp;

    assign is_first = r_idx == '0;
    assign is_last  = (32'(r_idx) + 32'd1) == 32'(r_n);

    // Commit checks: entry range and wrap counts, including last to first.
    always_comb begin
        first_raw  = is_first ? rd_raw : r_first_in;
        first_warp = is_first ? rd_warp : r_first_out;
        bad_range  = (MW'(rd_raw) >= r_mod) || (MW'(rd_warp) >= r_mod);
        rj_sum     = {1'b0, r_rj}
                   + 3'(!is_first && (r_prev_in >= rd_raw))
                   + 3'(is_last && (rd_raw >= first_raw));
        wj_sum     = {1'b0, r_wj}
                   + 3'(!is_first && (r_prev_out >= rd_warp))
                   + 3'(is_last && (rd_warp >= first_warp));
        rj_next    = (rj_sum > 3'd1) ? 2'd2 : rj_sum[1:0];
        wj_next    = (wj_sum > 3'd1) ? 2'd2 : wj_sum[1:0];
        wrap_bad   = (rj_next > 2'd1) || (wj_next > 2'd1);
    end

    // Segment test between the previous entry and the current one (or the
    // first entry, for the closing segment of the cycle).
    always_comb begin
        ei       = RW'(r_prev_in);
        oi       = RW'(r_prev_out);
        ej       = (r_state == S_W_LAST) ? RW'(r_first_in) : RW'(cur_in);
        oj       = (r_state == S_W_LAST) ? RW'(r_first_out) : RW'(cur_out);
        ev       = RW'(r_v);
        em       = RW'(r_mod);
        c1       = (ei <= ev) && (ev <= ej) && (ei != ej);
        wrap_seg = ei >= ej;
        c2       = wrap_seg && (ev >= ei);
        c3       = wrap_seg && (ev <= ej);
        seg_hit  = c1 || c2 || c3;
        b_w      = (oi >= oj) ? (oj + em - oi) : (oj - oi);
        a_w      = (c1 || c2) ? (ev - ei) : (ev + em - ei);
        d_w      = c1 ? (ej - ei) : (ej + em - ei);
    end

    // The sum stays below twice the modulus, so one subtract wraps it.
    always_comb begin
        if (r_state == S_W_DIV) begin
            frac = md_quo;
        end else if (r_d == '0) begin
            frac = '0;
        end else begin
            frac = r_b;
        end
        sum     = RW'(r_lo) + RW'(frac);
        wrapped = (sum >= RW'(r_mod)) ? (sum - RW'(r_mod)) : sum;
        direct  = (r_d == '0) || (r_a >= r_d);
    end

    always_comb begin
        n_state    = r_state;
        ram_we     = 1'b0;
        ram_waddr  = base_act;
        ram_wraw   = '0;
        ram_wwarp  = '0;
        ram_raddr  = base_act + AW'(r_idx);
        md_cmd.go  = 1'b0;
        md_cmd.op  = MD_MOD;
        md_num     = MW'(i_value_in);
        md_den     = r_mod;
        fin        = 1'b0;
        fin_status = 1'b0;
        fin_value  = '0;
        case (r_state)
            S_INIT: begin
                ram_we  = 1'b1;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (cfg_we) begin
                    n_state = S_INIT;
                end else if (accept) begin
                    case (t_func'(i_func))
                        FN_LOAD: begin
                            ram_we    = idx_ok;
                            ram_waddr = base_stg + AW'(i_point_index);
                            ram_wraw  = i_raw_point;
                            ram_wwarp = i_warped_point;
                            fin       = 1'b1;
                        end
                        FN_COMMIT: begin
                            if (cnt_bad) begin
                                fin        = 1'b1;
                                fin_status = 1'b1;
                            end else begin
                                n_state = S_CMT_RD;
                            end
                        end
                        FN_FWD, FN_INV: begin
                            md_cmd.go = 1'b1;
                            n_state   = S_W_MODW;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CMT_RD: begin
                ram_raddr = base_stg + AW'(r_idx);
                n_state   = S_CMT_CMP;
            end
            S_CMT_CMP: begin
                if (bad_range || is_last) begin
                    fin        = 1'b1;
                    fin_status = bad_range || wrap_bad;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_CMT_RD;
                end
            end
            S_W_MODW: begin
                if (md_done) begin
                    n_state = S_W_RD;
                end
            end
            S_W_RD: begin
                n_state = S_W_CMP;
            end
            S_W_CMP: begin
                if (!is_first && seg_hit) begin
                    n_state = S_W_LERP;
                end else if (is_last) begin
                    n_state = S_W_LAST;
                end else begin
                    n_state = S_W_RD;
                end
            end
            S_W_LAST: begin
                if (seg_hit) begin
                    n_state = S_W_LERP;
                end else begin
                    fin       = 1'b1;
                    fin_value = r_v;
                    n_state   = S_IDLE;
                end
            end
            S_W_LERP: begin
                if (direct) begin
                    fin       = 1'b1;
                    fin_value = wrapped[VB-1:0];
                    n_state   = S_IDLE;
                end else begin
                    md_cmd.go = 1'b1;
                    md_cmd.op = MD_MULDIV;
                    md_num    = r_a;
                    md_den    = r_d;
                    n_state   = S_W_DIV;
                end
            end
            S_W_DIV: begin
                if (md_done) begin
                    fin       = 1'b1;
                    fin_value = wrapped[VB-1:0];
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod    <= M_MAX;
            r_bank   <= 1'b0;
            r_count  <= CW'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= fin;
            if (cfg_we) begin
                r_mod   <= cfg_m;
                r_count <= CW'(1);
            end
            if (r_state == S_CMT_CMP && is_last && !bad_range && !wrap_bad) begin
                r_bank  <= ~r_bank;
                r_count <= r_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_inv <= i_func == FN_INV;
            r_idx <= '0;
            r_rj  <= 2'd0;
            r_wj  <= 2'd0;
            r_n   <= (i_func == FN_COMMIT) ? CW'(i_point_count) : r_count;
        end
        case (r_state)
            S_CMT_CMP: begin
                r_prev_in  <= rd_raw;
                r_prev_out <= rd_warp;
                if (is_first) begin
                    r_first_in  <= rd_raw;
                    r_first_out <= rd_warp;
                end
                r_rj  <= rj_next;
                r_wj  <= wj_next;
                r_idx <= r_idx + IW'(1);
            end
            S_W_MODW: begin
                if (md_done) begin
                    r_v <= md_rem[VB-1:0];
                end
            end
            S_W_CMP: begin
                if (!is_first && seg_hit) begin
                    r_a  <= a_w[MW-1:0];
                    r_b  <= b_w[MW-1:0];
                    r_d  <= d_w[MW-1:0];
                    r_lo <= r_prev_out;
                end
                r_prev_in  <= cur_in;
                r_prev_out <= cur_out;
                if (is_first) begin
                    r_first_in  <= cur_in;
                    r_first_out <= cur_out;
                end
                r_idx <= r_idx + IW'(1);
            end
            S_W_LAST: begin
                if (seg_hit) begin
                    r_a  <= a_w[MW-1:0];
                    r_b  <= b_w[MW-1:0];
                    r_d  <= d_w[MW-1:0];
                    r_lo <= r_prev_out;
                end
            end
            default: begin
                r_lo <= r_lo;
            end
        endcase
        if (fin) begin
            r_value_out <= fin_value;
            r_status    <= fin_status;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_value_out = r_value_out;
    assign o_status    = r_status;

    a_load_result_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == FN_LOAD) |=> o_valid)
        else $error("load item did not give its result on the next cycle");

    a_warp_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_func == FN_FWD || i_func == FN_INV)) |=> busy)
        else $error("warp item accepted without the block going busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (32'(r_count) <= MAX_POINTS))
        else $error("active point count out of range");

    a_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mod >= MW'(2)) && (r_mod <= M_MAX))
        else $error("effective modulus out of range");

    a_md_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_done |-> (r_state == S_W_MODW || r_state == S_W_DIV))
        else $error("arithmetic unit finished while nobody waited for it");

    a_cfg_not_with_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cfg_we && accept))
        else $error("configuration write taken together with an item");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for cyclic_piecewise_linear_warp: table loads, commits and warps.
// Depends on cpw_pkg and the RTL top level, which in turn needs cpw_ram and cpw_muldiv.
module tb;
    import cpw_pkg::*;

    localparam int MAX_PTS = MAX_POINTS_DEF;
    localparam int VBITS = VALUE_BITS_DEF;
    localparam longint unsigned M_FULL = 64'd1 << VBITS;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int NUM_PHASES = 9;

    typedef struct packed {
        t_func                  func;
        logic [INDEX_BITS-1:0]  index;
        logic [VBITS-1:0]       raw_pt;
        logic [VBITS-1:0]       warped_pt;
        logic [COUNT_BITS-1:0]  count;
        logic [VBITS-1:0]       value;
    } warp_item_t;

    typedef struct packed {
        logic [VBITS-1:0] value;
        logic             status;
    } warp_result_t;

    typedef logic [VBITS-1:0] point_q_t [$];

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic o_valid;
    logic [VBITS-1:0] o_value_out;
    logic o_status;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [VBITS:0] i_cfg_modulus = '0;
    warp_item_t cur_item = '0;

    // Predicted block state, owned by the monitor.
    logic [VBITS:0]   modulus_reg = 17'd65536;
    logic [VBITS-1:0] raw_pts [0:2*MAX_PTS-1] = '{default: '0};
    logic [VBITS-1:0] warped_pts [0:2*MAX_PTS-1] = '{default: '0};
    int               active_count = 1;
    bit               active_bank = 1'b0;

    warp_item_t   pending_items [$];
    warp_result_t expected_outputs [$];
    point_q_t     recent_points;
    logic [VBITS:0] mod_setting = 17'd65536;
    logic [VBITS:0] phase_moduli [0:NUM_PHASES-1] = '{17'd65536, 17'd2, 17'd36000, 17'd0,
        17'd131071, 17'd1, 17'd257, 17'd1000, 17'd65537};
    int idle_pct = 34;
    int queued_count = 0;
    int issued_total = 0;
    int accepted_total = 0;
    int cfg_writes_seen = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    cyclic_piecewise_linear_warp dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (cur_item.func),
        .i_point_index  (cur_item.index),
        .i_raw_point    (cur_item.raw_pt),
        .i_warped_point (cur_item.warped_pt),
        .i_point_count  (cur_item.count),
        .i_value_in     (cur_item.value),
        .o_valid        (o_valid),
        .o_value_out    (o_value_out),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_modulus  (i_cfg_modulus)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint unsigned cycle_length(logic [VBITS:0] reg_val);
        longint unsigned m;
        m = reg_val;
        if (m < 2) m = 2;
        if (m > M_FULL) m = M_FULL;
        return m;
    endfunction

    function automatic longint unsigned interpolate(longint unsigned lo, a, span_in, span_out);
        if (span_in == 0) return lo;
        if (a >= span_in) return lo + span_out;
        return lo + (a * span_out) / span_in;
    endfunction

    // Segment search over the active bank; a segment may run across the wrap point.
    function automatic logic [VBITS-1:0] warp_lookup(bit inverse, logic [VBITS-1:0] x);
        longint unsigned m, v, res, in_i, in_j, out_i, out_j, span_out;
        int n, i, j, base;
        bit found;
        m = cycle_length(modulus_reg);
        v = x % m;
        res = v;
        n = active_count;
        if (n < 1 || n > MAX_PTS) n = 1;
        base = active_bank ? MAX_PTS : 0;
        found = 1'b0;
        for (i = 0; i < n && !found; i++) begin
            j = (i + 1) % n;
            in_i = inverse ? warped_pts[base + i] : raw_pts[base + i];
            in_j = inverse ? warped_pts[base + j] : raw_pts[base + j];
            out_i = inverse ? raw_pts[base + i] : warped_pts[base + i];
            out_j = inverse ? raw_pts[base + j] : warped_pts[base + j];
            span_out = (out_i >= out_j) ? out_j + m - out_i : out_j - out_i;
            if (in_i <= v && v <= in_j && in_i != in_j) begin
                res = interpolate(out_i, v - in_i, in_j - in_i, span_out);
                found = 1'b1;
            end else if (in_i >= in_j && v >= in_i) begin
                res = interpolate(out_i, v - in_i, in_j + m - in_i, span_out);
                found = 1'b1;
            end else if (in_i >= in_j && v <= in_j) begin
                res = interpolate(out_i, v + m - in_i, in_j + m - in_i, span_out);
                found = 1'b1;
            end
        end
        return VBITS'(res % m);
    endfunction

    function automatic warp_result_t predict_output(warp_item_t it);
        warp_result_t res;
        longint unsigned m;
        int stage, n, i, j, raw_wraps, warped_wraps;
        bit ok;
        res = '0;
        m = cycle_length(modulus_reg);
        stage = active_bank ? 0 : MAX_PTS;
        case (it.func)
            FN_LOAD: begin
                raw_pts[stage + int'(it.index)] = it.raw_pt;
                warped_pts[stage + int'(it.index)] = it.warped_pt;
            end
            FN_COMMIT: begin
                n = it.count;
                ok = (n >= 1 && n <= MAX_PTS);
                raw_wraps = 0;
                warped_wraps = 0;
                for (i = 0; ok && i < n; i++) begin
                    j = (i + 1) % n;
                    if (raw_pts[stage + i] >= m || warped_pts[stage + i] >= m) ok = 1'b0;
                    if (raw_pts[stage + i] >= raw_pts[stage + j]) raw_wraps++;
                    if (warped_pts[stage + i] >= warped_pts[stage + j]) warped_wraps++;
                end
                if (raw_wraps > 1 || warped_wraps > 1) ok = 1'b0;
                if (ok) begin
                    active_bank = !active_bank;
                    active_count = n;
                end else begin
                    res.status = 1'b1;
                end
            end
            FN_FWD: res.value = warp_lookup(1'b0, it.value);
            FN_INV: res.value = warp_lookup(1'b1, it.value);
        endcase
        return res;
    endfunction

    function automatic warp_item_t random_item(t_func f);
        warp_item_t it;
        it.func = f;
        it.index = INDEX_BITS'($urandom_range(MAX_PTS - 1));
        it.raw_pt = VBITS'($urandom_range(65535));
        it.warped_pt = VBITS'($urandom_range(65535));
        it.count = COUNT_BITS'($urandom_range(31));
        it.value = VBITS'($urandom_range(65535));
        return it;
    endfunction

    function automatic point_q_t unique_sorted(int n, longint unsigned m);
        point_q_t pts;
        logic [VBITS-1:0] v;
        bit dup;
        while (pts.size() < n) begin
            v = VBITS'($urandom_range(32'(m - 1)));
            dup = 1'b0;
            foreach (pts[k]) if (pts[k] == v) dup = 1'b1;
            if (!dup) pts.push_back(v);
        end
        pts.sort();
        return pts;
    endfunction

    task automatic push_item(warp_item_t it);
        pending_items.push_back(it);
        queued_count++;
    endtask

    task automatic push_load(logic [INDEX_BITS-1:0] idx, logic [VBITS-1:0] r, logic [VBITS-1:0] w);
        warp_item_t it;
        it = random_item(FN_LOAD);
        it.index = idx;
        it.raw_pt = r;
        it.warped_pt = w;
        push_item(it);
    endtask

    task automatic push_commit(logic [COUNT_BITS-1:0] n);
        warp_item_t it;
        it = random_item(FN_COMMIT);
        it.count = n;
        push_item(it);
    endtask

    task automatic push_warp(t_func f, logic [VBITS-1:0] v);
        warp_item_t it;
        it = random_item(f);
        it.value = v;
        push_item(it);
    endtask

    task automatic queue_transforms(int k);
        logic [VBITS-1:0] v;
        repeat (k) begin
            v = VBITS'($urandom_range(65535));
            // Hitting the table points exactly exercises the segment end cases.
            if (recent_points.size() != 0 && $urandom_range(3) == 0)
                v = recent_points[$urandom_range(recent_points.size() - 1)];
            push_warp($urandom_range(1) ? FN_FWD : FN_INV, v);
        end
    endtask

    // A well-formed table: increasing sequences rotated so each wraps once.
    // When flaws are allowed, some tables are spoiled by a point out of range,
    // an extra wrap, or a bad count; others may commit more points than loaded.
    task automatic queue_table(int n, bit may_break);
        point_q_t raws, warps;
        longint unsigned m;
        int rot_r, rot_w, k, count, flaw;
        logic [VBITS-1:0] r, w;
        m = cycle_length(mod_setting);
        if (n > m) n = int'(m);
        raws = unique_sorted(n, m);
        warps = unique_sorted(n, m);
        rot_r = $urandom_range(n - 1);
        rot_w = $urandom_range(n - 1);
        flaw = (may_break && $urandom_range(99) < 20) ? $urandom_range(3, 1) : 0;
        count = n;
        recent_points.delete();
        for (k = 0; k < n; k++) begin
            r = raws[(k + rot_r) % n];
            w = warps[(k + rot_w) % n];
            if (flaw == 1 && k == n - 1 && m < M_FULL) r = VBITS'($urandom_range(65535, 32'(m)));
            push_load(INDEX_BITS'(k), r, w);
            recent_points.push_back(r);
            recent_points.push_back(w);
        end
        if (flaw == 2) push_load('0, raws[(1 + rot_r) % n], warps[rot_w]);
        if (flaw == 3) count = $urandom_range(1) ? 0 : $urandom_range(31, MAX_PTS + 1);
        else if (flaw == 0 && $urandom_range(99) < 20) count = $urandom_range(MAX_PTS, n);
        push_commit(COUNT_BITS'(count));
        queue_transforms($urandom_range(8, 2));
    endtask

    task automatic queue_phase(int budget);
        int first, pick;
        first = queued_count;
        while (queued_count - first < budget) begin
            pick = $urandom_range(99);
            if (pick < 60)
                queue_table(($urandom_range(3) == 0) ? $urandom_range(MAX_PTS, 7)
                                                    : $urandom_range(6, 1), 1'b1);
            else if (pick < 78)
                queue_transforms($urandom_range(6, 1));
            else if (pick < 90)
                push_item(random_item(FN_LOAD));
            else
                push_item(random_item(FN_COMMIT));
        end
    endtask

    task automatic wait_for_drain();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || start || expected_outputs.size() != 0);
    endtask

    // Driver: a new item goes out only once the previous one has been taken.
    always @(negedge i_clk) begin
        warp_item_t next_item;
        if (i_rst_n && accepted_total == issued_total) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
                next_item = pending_items.pop_front();
                cur_item <= next_item;
                issued_total++;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks results, predicts accepted items and tracks register writes.
    always @(posedge i_clk) begin
        warp_result_t want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_outputs.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("cycle %0d: result with none expected: value_out %0d status %0d",
                                 cycle_count, o_value_out, o_status);
                    mismatch_count++;
                end else begin
                    want = expected_outputs.pop_front();
                    if (o_value_out !== want.value || o_status !== want.status) begin
                        if (mismatch_count < 10)
                            $display("cycle %0d: value_out exp %0d got %0d, status exp %0d got %0d",
                                     cycle_count, want.value, o_value_out, want.status, o_status);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy) begin
                expected_outputs.push_back(predict_output(cur_item));
                accepted_total++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                // A new modulus also puts the active table back to the identity.
                modulus_reg = i_cfg_modulus;
                active_count = 1;
                raw_pts[active_bank ? MAX_PTS : 0] = '0;
                warped_pts[active_bank ? MAX_PTS : 0] = '0;
                cfg_writes_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int p, writes;
        phase_moduli[7] = 17'($urandom_range(65535, 3));
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Identity table after reset, at both ends of the range.
        push_warp(FN_FWD, 16'd0);
        push_warp(FN_FWD, 16'd65535);
        push_warp(FN_INV, 16'd65535);
        // Commits with a count of zero or above the table size are refused.
        push_commit(5'd0);
        push_commit(5'd17);
        push_commit(5'd31);
        // Four points, both sequences wrapping once; first spoiled by a second raw wrap.
        push_load(4'd0, 16'd1000, 16'd50000);
        push_load(4'd1, 16'd500, 16'd5000);
        push_load(4'd2, 16'd40000, 16'd30000);
        push_load(4'd3, 16'd60000, 16'd45000);
        push_commit(5'd4);
        push_load(4'd1, 16'd20000, 16'd5000);
        push_commit(5'd4);
        // Inside the wrapping segment on both sides, on a point, and between points.
        push_warp(FN_FWD, 16'd500);
        push_warp(FN_FWD, 16'd65000);
        push_warp(FN_FWD, 16'd20000);
        push_warp(FN_FWD, 16'd30000);
        push_warp(FN_INV, 16'd0);
        push_warp(FN_INV, 16'd65535);
        push_load(4'd15, 16'd65535, 16'd65535);
        push_warp(FN_INV, 16'd45000);

        // Two full tables fill every entry of both banks before anything else commits.
        queue_table(MAX_PTS, 1'b0);
        queue_table(MAX_PTS, 1'b0);
        queue_phase(180);
        wait_for_drain();

        for (p = 0; p < NUM_PHASES; p++) begin
            idle_pct = (p == 2) ? 0 : 34;
            repeat (8) @(negedge i_clk);
            i_cfg_modulus <= phase_moduli[p];
            i_cfg_valid <= 1'b1;
            writes = cfg_writes_seen + 1;
            do @(negedge i_clk);
            while (cfg_writes_seen != writes);
            i_cfg_valid <= 1'b0;
            mod_setting = phase_moduli[p];
            @(posedge i_clk);
            queue_phase(200);
            wait_for_drain();
        end

        repeat (200) @(posedge i_clk);
        if (expected_outputs.size() != 0)
            $display("%0d expected results never arrived", expected_outputs.size());
        if (mismatch_count == 0 && expected_outputs.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
